[rtl/core/back_forward_history_assert.svh]
// assertion macros used by the rtl
`ifndef BACK_FORWARD_HISTORY_ASSERT_SVH
`define BACK_FORWARD_HISTORY_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BFH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfh assertion failed");

// next-cycle implication, checked out of reset
`define BFH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfh assertion failed");

`endif

[rtl/core/bfh_pkg.sv]
package bfh_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int OFF_W   = ADDR_W + 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    localparam int PAGE_W  = 32;
    localparam int YPOS_W  = 32;
    localparam int ENTRY_W = PAGE_W + YPOS_W;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_BACK  = 2'd1,
        CMD_FWD   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // ring slot of an offset counted from the oldest entry
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                 input logic [OFF_W-1:0] off);
        logic [ADDR_W+1:0] sum;
        sum = (ADDR_W+2)'(base) + (ADDR_W+2)'(off);
        if (sum >= (ADDR_W+2)'(DEPTH))
        begin
            sum = sum - (ADDR_W+2)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

[rtl/core/back_forward_history.sv]
// channel  | dir | beat contents
// s        | in  | tdata: page[31:0] ypos[63:32]; tuser: command[1:0]
// m        | out | tdata: entry_page[31:0] entry_ypos[63:32] can_back[64]
//          |     |        can_forward[65] zero[71:66]; tuser: entry_valid[0]
//
// each command is accepted in the idle state, which reads one entry of the
// ring memory; the execute state then compares, returns or overwrites the
// registered read data while the pointers update
// the result sits in the output register; the next beat is accepted while it waits
// the execute cycle holds while the output register is still full
// reset empties the history at once; the ring memory itself is not cleared
module back_forward_history (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // page, ypos
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // entry_page, entry_ypos, can_back, can_forward, zero
    output logic [0:0]  m_tuser    // entry_valid
);

    `include "back_forward_history_assert.svh"

    localparam int AW = bfh_pkg::ADDR_W;
    localparam int OW = bfh_pkg::OFF_W;
    localparam int CW = bfh_pkg::COUNT_W;
    localparam int PW = bfh_pkg::PAGE_W;
    localparam int YW = bfh_pkg::YPOS_W;
    localparam int EW = bfh_pkg::ENTRY_W;
    localparam int MW = bfh_pkg::M_TDATA_W;
    localparam int DP = bfh_pkg::DEPTH;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t            state_reg;
    bfh_pkg::cmd_t     cmd_reg;
    logic [PW-1:0]     page_reg;
    logic [YW-1:0]     ypos_reg;
    logic [AW-1:0]     oldest_reg, oldest_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     cursor_reg, cursor_next;
    logic              m_tvalid_reg;
    logic [MW-1:0]     m_tdata_reg;
    logic              m_tuser_reg;

    logic              accept;
    logic              fire;
    bfh_pkg::cmd_t     cmd_in;
    logic [AW-1:0]     rd_addr;
    logic [EW-1:0]     rd_data;
    logic              we;
    logic [AW-1:0]     wr_addr;
    logic [OW-1:0]     cursor_ext, count_ext, cur_plus;
    logic              st_back, st_fwd;
    logic              out_valid, out_back, out_fwd;
    logic [PW-1:0]     out_page;
    logic [YW-1:0]     out_ypos;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign cmd_in   = bfh_pkg::cmd_t'(s_tuser);

    assign cursor_ext = OW'(cursor_reg);
    assign count_ext  = OW'(count_reg);
    assign cur_plus   = cursor_ext + OW'(1);
    assign st_back    = (count_reg != '0) && (cursor_reg != '0);
    assign st_fwd     = (count_reg != '0) && (cur_plus < count_ext);

    // read address for the entry the command will need
    always_comb
    begin
        unique case (cmd_in)
            bfh_pkg::CMD_ADD:
                rd_addr = bfh_pkg::slot_of(oldest_reg, cursor_ext);
            bfh_pkg::CMD_BACK:
                rd_addr = (cursor_reg == '0) ? oldest_reg
                                             : bfh_pkg::slot_of(oldest_reg,
                                                                cursor_ext - OW'(1));
            bfh_pkg::CMD_FWD:
                rd_addr = bfh_pkg::slot_of(oldest_reg, cur_plus);
            bfh_pkg::CMD_CLEAR:
                rd_addr = oldest_reg;
            default:
                rd_addr = oldest_reg;
        endcase
    end

    bfh_ram #(
        .DATA_W (EW),
        .ADDR_W (AW),
        .DEPTH  (DP)
    ) u_ram (
        .clk   (clk),
        .we    (we && fire),
        .waddr (wr_addr),
        .wdata ({page_reg, ypos_reg}),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        we          = 1'b0;
        wr_addr     = oldest_reg;
        out_valid   = 1'b0;
        out_page    = '0;
        out_ypos    = '0;
        out_back    = st_back;
        out_fwd     = st_fwd;
        unique case (cmd_reg)
            bfh_pkg::CMD_ADD:
            begin
                if (count_reg == '0)
                begin
                    we          = 1'b1;
                    wr_addr     = oldest_reg;
                    count_next  = CW'(1);
                    cursor_next = '0;
                    out_back    = 1'b0;
                    out_fwd     = 1'b0;
                end
                else if (rd_data != {page_reg, ypos_reg})
                begin
                    we      = 1'b1;
                    wr_addr = bfh_pkg::slot_of(oldest_reg, cur_plus);
                    if (cur_plus == OW'(DP))
                    begin
                        // ring full at the cursor: the oldest entry goes
                        oldest_next = bfh_pkg::slot_of(oldest_reg, OW'(1));
                        cursor_next = AW'(DP - 1);
                        count_next  = CW'(DP);
                    end
                    else
                    begin
                        cursor_next = cur_plus[AW-1:0];
                        count_next  = CW'(cur_plus + OW'(1));
                    end
                    out_back = 1'b1;
                    out_fwd  = 1'b0;
                end
            end
            bfh_pkg::CMD_BACK:
            begin
                if (st_back)
                begin
                    cursor_next = cursor_reg - AW'(1);
                    out_valid   = 1'b1;
                    out_page    = rd_data[EW-1:YW];
                    out_ypos    = rd_data[YW-1:0];
                    out_back    = (cursor_reg != AW'(1));
                    out_fwd     = 1'b1;
                end
            end
            bfh_pkg::CMD_FWD:
            begin
                if (st_fwd)
                begin
                    cursor_next = cur_plus[AW-1:0];
                    out_valid   = 1'b1;
                    out_page    = rd_data[EW-1:YW];
                    out_ypos    = rd_data[YW-1:0];
                    out_back    = 1'b1;
                    out_fwd     = (cur_plus + OW'(1)) < count_ext;
                end
            end
            bfh_pkg::CMD_CLEAR:
            begin
                oldest_next = '0;
                count_next  = '0;
                cursor_next = '0;
                out_back    = 1'b0;
                out_fwd     = 1'b0;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            oldest_reg   <= '0;
            count_reg    <= '0;
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (fire)
            begin
                oldest_reg   <= oldest_next;
                count_reg    <= count_next;
                cursor_reg   <= cursor_next;
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {(MW - PW - YW - 2)'(0), out_fwd, out_back, out_ypos, out_page};
                m_tuser_reg  <= out_valid;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_in;
            page_reg <= s_tdata[PW-1:0];
            ypos_reg <= s_tdata[PW+YW-1:PW];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `BFH_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DP))
    `BFH_ASSERT_IMP(a_cursor_inside, count_reg != '0, cursor_ext < count_ext)
    `BFH_ASSERT_IMP(a_empty_home, count_reg == '0, cursor_reg == '0 && oldest_reg == '0)
    `BFH_ASSERT_IMP(a_moved_flags, m_tvalid && m_tuser[0], m_tdata[64] || m_tdata[65])
    `BFH_ASSERT_NEXT(a_fire_shows, fire, m_tvalid && state_reg == ST_IDLE)

endmodule

[rtl/core/bfh_ram.sv]
module bfh_ram #(
    parameter int DATA_W = 64,
    parameter int ADDR_W = 4,
    parameter int DEPTH  = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
